// ----- hw/rtl/abz_encoder_angle_speed_unit_assert.svh -----
// Assertion macros for the encoder angle and speed unit.
// ABZ_ASSERT_IMP: same-cycle implication, ABZ_ASSERT_NXT: next-cycle implication.
// Both sample on clock and hold off while reset is high.
`ifndef ABZ_ENCODER_ANGLE_SPEED_UNIT_ASSERT_SVH
`define ABZ_ENCODER_ANGLE_SPEED_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ABZ_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("abz check failed");
`define ABZ_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("abz check failed");
`else
`define ABZ_ASSERT_IMP(label, ante, cons)
`define ABZ_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- hw/rtl/abz_pkg.sv -----
package abz_pkg;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FRAC,
      ST_ELEC,
      ST_WRAP,
      ST_SPEED,
      ST_FINISH
   } state_type;

   typedef logic [2:0] csr_index_type;

   // commands (code 3 behaves as an angle update)
   localparam logic [1:0] CMD_ANGLE = 2'd0;
   localparam logic [1:0] CMD_SPEED = 2'd1;
   localparam logic [1:0] CMD_CALIB = 2'd2;

   // calibration phases
   localparam logic [1:0] CAL_IDLE   = 2'd0;
   localparam logic [1:0] CAL_VOTE   = 2'd1;
   localparam logic [1:0] CAL_SETTLE = 2'd2;
   localparam logic [1:0] CAL_BAD    = 2'd3;

   // register indexes
   localparam csr_index_type REG_COUNTS_PER_REV  = 3'd0;
   localparam csr_index_type REG_ANGLE_GAIN      = 3'd1;
   localparam csr_index_type REG_POLE_PAIR_COUNT = 3'd2;
   localparam csr_index_type REG_SPEED_GAIN      = 3'd3;
   localparam csr_index_type REG_SETTLE_STEPS    = 3'd4;

   // serial multiplier geometry
   localparam int MCAND_BITS  = 32;
   localparam int MPLIER_BITS = 25;
   localparam int ACC_BITS    = MCAND_BITS + MPLIER_BITS;

   // multiplier bits walked per operation
   localparam logic [4:0] FRAC_STEPS  = 5'd16;
   localparam logic [4:0] ELEC_STEPS  = 5'd6;
   localparam logic [4:0] WRAP_STEPS  = 5'd8;
   localparam logic [4:0] SPEED_STEPS = 5'd25;

endpackage

// ----- hw/rtl/abz_encoder_angle_speed_unit.sv -----
// Angle, speed and calibration unit for an ABZ quadrature encoder.
// An angle, calibration or spare command runs the angle and electrical multiplies; a speed
// command also runs the wrap and speed multiplies. A new item is taken only once the last
// result has committed to the output register. Every multiply runs on the
// shared bit-serial multiplier, which walks one multiplier bit per cycle.
// Reset (synchronous, active high) loads the register defaults and clears the control and persistent block state.
`include "abz_encoder_angle_speed_unit_assert.svh"

module abz_encoder_angle_speed_unit #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // input item channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_command,
   input  logic [15:0]           req_count_value,
   input  logic                  req_count_down,
   input  logic [7:0]            req_wraps_since_last,
   input  logic                  req_index_seen,
   // result item channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [15:0]           rsp_mech_angle,
   output logic [15:0]           rsp_elec_angle,
   output logic signed [31:0]    rsp_speed_rpm,
   output logic                  rsp_calib_done,
   output logic                  rsp_mount_negative,
   // register write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  abz_pkg::csr_index_type csr_index,
   input  logic [31:0]           csr_data
);
   import abz_pkg::*;

   // Angle precision: keep the top ANGLE_BITS of the turn fraction, zero the rest.
   localparam int ANGLE_DROP = (ANGLE_BITS >= 16) ? 0 : 16 - ANGLE_BITS;
   localparam logic [15:0] ANGLE_MASK = 16'hFFFF << ANGLE_DROP;

   // configuration registers
   logic [15:0] counts_per_rev_ff;
   logic [31:0] angle_gain_ff;
   logic [5:0]  pole_pair_count_ff;
   logic [31:0] speed_gain_ff;
   logic [15:0] settle_steps_ff;

   // sequencer
   state_type state_ff, state_in;

   // held item fields
   logic [1:0]  cmd_ff, cmd_in;
   logic [15:0] cnt_ff, cnt_in;
   logic        down_ff, down_in;
   logic [7:0]  wraps_ff, wraps_in;
   logic        index_ff, index_in;

   // persistent block state
   logic [15:0]        prev_count_ff, prev_count_in;
   logic signed [15:0] votes_ff, votes_in;
   logic [15:0]        offset_ff, offset_in;
   logic [1:0]         cal_phase_ff, cal_phase_in;
   logic [15:0]        settle_ff, settle_in;

   // bit-serial multiplier: multiplicand, multiplier shift line, accumulator, step count
   logic [MCAND_BITS-1:0]  mcand_ff, mcand_in;
   logic [MPLIER_BITS-1:0] mplier_ff, mplier_in;
   logic [ACC_BITS-1:0]    acc_ff, acc_in;
   logic [4:0]             steps_ff, steps_in;
   logic [MCAND_BITS:0]    acc_sum;
   logic                   mul_busy;

   // working results
   logic [15:0]        mech_ff, mech_in;
   logic [15:0]        elec_ff, elec_in;
   logic signed [31:0] rpm_ff, rpm_in;
   logic               neg_ff, neg_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_mech_ff, rsp_mech_in;
   logic [15:0]        rsp_elec_ff, rsp_elec_in;
   logic signed [31:0] rsp_rpm_ff, rsp_rpm_in;
   logic               rsp_done_ff, rsp_done_in;
   logic               rsp_mneg_ff, rsp_mneg_in;

   // combinational helpers
   logic [31:0]        frac;
   logic [31:0]        efrac;
   logic [15:0]        elec_raw;
   logic [15:0]        elec_fin;
   logic [23:0]        wrap_prod;
   logic signed [17:0] c_s, p_s, prev_s, base;
   logic signed [25:0] delta, delta_neg;
   logic [24:0]        mag;
   logic [40:0]        q;
   logic               commit;
   logic               req_take;

   assign req_stall          = (state_ff != ST_IDLE);
   assign req_take           = req_valid && !req_stall;
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mech_angle     = rsp_mech_ff;
   assign rsp_elec_angle     = rsp_elec_ff;
   assign rsp_speed_rpm      = rsp_rpm_ff;
   assign rsp_calib_done     = rsp_done_ff;
   assign rsp_mount_negative = rsp_mneg_ff;

   // One multiplier bit per cycle: add the multiplicand into the top of the accumulator
   // when the low multiplier bit is set, then shift the accumulator right.
   assign mul_busy = (steps_ff != 5'd0);
   assign acc_sum  = {1'b0, acc_ff[ACC_BITS-1:MPLIER_BITS]}
                   + (mplier_ff[0] ? {1'b0, mcand_ff} : {(MCAND_BITS + 1){1'b0}});

   // After n steps the product sits at acc >> (MPLIER_BITS - n); pick the low 32 bits.
   assign frac      = acc_ff[40:9];    // count x angle_gain, 16 steps
   assign efrac     = acc_ff[50:19];   // frac x pole pair count, 6 steps
   assign wrap_prod = acc_ff[40:17];   // (wraps - 1) x counts_per_rev, 8 steps
   assign q         = acc_ff[56:16];   // |delta| x speed_gain >> 16, 25 steps

   // Electrical angle: scaled fraction plus offset, mirrored when mounted reversed.
   assign elec_raw = (efrac[31:16] & ANGLE_MASK) + offset_ff;
   assign elec_fin = votes_ff[15] ? (16'd0 - elec_raw) : elec_raw;

   // Count delta, corrected for a wrap of the counter since the last speed update.
   assign c_s    = $signed({2'b00, cnt_ff});
   assign p_s    = $signed({2'b00, counts_per_rev_ff});
   assign prev_s = $signed({2'b00, prev_count_ff});
   always_comb begin
      if (!down_ff) begin
         base = (wraps_ff != 8'd0) ? (c_s + (p_s - prev_s)) : (c_s - prev_s);
      end else begin
         base = (wraps_ff != 8'd0) ? (prev_s + (p_s - c_s)) : (prev_s - c_s);
      end
   end
   assign delta     = {{8{base[17]}}, base} + $signed({2'b00, wrap_prod});
   assign delta_neg = -delta;
   assign mag       = delta[25] ? delta_neg[24:0] : delta[24:0];

   // Result commits once the output register is free or being emptied.
   assign commit = (state_ff == ST_FINISH) && !(rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      cnt_in        = cnt_ff;
      down_in       = down_ff;
      wraps_in      = wraps_ff;
      index_in      = index_ff;
      prev_count_in = prev_count_ff;
      votes_in      = votes_ff;
      offset_in     = offset_ff;
      cal_phase_in  = cal_phase_ff;
      settle_in     = settle_ff;
      mcand_in      = mcand_ff;
      mplier_in     = mplier_ff;
      acc_in        = acc_ff;
      steps_in      = steps_ff;
      mech_in       = mech_ff;
      elec_in       = elec_ff;
      rpm_in        = rpm_ff;
      neg_in        = neg_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_mech_in   = rsp_mech_ff;
      rsp_elec_in   = rsp_elec_ff;
      rsp_rpm_in    = rsp_rpm_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_mneg_in   = rsp_mneg_ff;

      unique case (state_ff) inside
         ST_IDLE: begin
            if (req_take) begin
               // hold the item and start count x angle_gain
               cmd_in    = req_command;
               cnt_in    = req_count_value;
               down_in   = req_count_down;
               wraps_in  = req_wraps_since_last;
               index_in  = req_index_seen;
               rpm_in    = 32'sd0;
               mcand_in  = angle_gain_ff;
               mplier_in = {9'd0, req_count_value};
               acc_in    = '0;
               steps_in  = FRAC_STEPS;
               state_in  = ST_FRAC;
            end
         end
         ST_FRAC, ST_ELEC, ST_WRAP, ST_SPEED: begin
            if (mul_busy) begin
               // advance one multiplier bit
               acc_in    = {acc_sum, acc_ff[MPLIER_BITS-1:1]};
               mplier_in = mplier_ff >> 1;
               steps_in  = steps_ff - 5'd1;
            end else begin
               acc_in = '0;
               unique case (state_ff)
                  ST_FRAC: begin
                     mech_in   = frac[31:16] & ANGLE_MASK;
                     mcand_in  = frac;
                     mplier_in = {19'd0, pole_pair_count_ff};
                     steps_in  = ELEC_STEPS;
                     state_in  = ST_ELEC;
                  end
                  ST_ELEC: begin
                     elec_in = elec_fin;
                     if (cmd_ff == CMD_SPEED) begin
                        mcand_in  = {16'd0, counts_per_rev_ff};
                        mplier_in = (wraps_ff > 8'd1) ? {17'd0, wraps_ff - 8'd1} : '0;
                        steps_in  = WRAP_STEPS;
                        state_in  = ST_WRAP;
                     end else begin
                        state_in = ST_FINISH;
                     end
                  end
                  ST_WRAP: begin
                     // sign flips for a down count and for a reversed mounting
                     neg_in    = delta[25] ^ down_ff ^ votes_ff[15];
                     mcand_in  = speed_gain_ff;
                     mplier_in = mag;
                     steps_in  = SPEED_STEPS;
                     state_in  = ST_SPEED;
                  end
                  default: begin
                     // saturate to the signed 32-bit range
                     if (neg_ff) begin
                        if ((q[40:32] != 9'd0) || (q[31] && (q[30:0] != 31'd0))) begin
                           rpm_in = 32'sh8000_0000;
                        end else begin
                           rpm_in = $signed(32'd0 - q[31:0]);
                        end
                     end else begin
                        if (q[40:31] != 10'd0) begin
                           rpm_in = 32'sh7FFF_FFFF;
                        end else begin
                           rpm_in = $signed(q[31:0]);
                        end
                     end
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_FINISH: begin
            if (commit) begin
               rsp_done_in = 1'b0;
               if (cmd_ff == CMD_SPEED) begin
                  prev_count_in = cnt_ff;
               end else if (cmd_ff == CMD_CALIB) begin
                  unique case (cal_phase_ff)
                     CAL_IDLE: begin
                        settle_in    = 16'd0;
                        offset_in    = 16'd0;
                        cal_phase_in = CAL_VOTE;
                     end
                     CAL_VOTE: begin
                        // saturating direction vote
                        if (down_ff) begin
                           if (votes_ff != 16'sh8000) votes_in = votes_ff - 16'sd1;
                        end else begin
                           if (votes_ff != 16'sh7FFF) votes_in = votes_ff + 16'sd1;
                        end
                        if (index_ff) cal_phase_in = CAL_SETTLE;
                     end
                     CAL_SETTLE: begin
                        if (settle_ff >= settle_steps_ff) begin
                           offset_in    = votes_ff[15] ? elec_ff : (16'd0 - elec_ff);
                           rsp_done_in  = 1'b1;
                           cal_phase_in = CAL_IDLE;
                           settle_in    = 16'd0;
                        end else begin
                           settle_in = settle_ff + 16'd1;
                        end
                     end
                     CAL_BAD: begin
                        cal_phase_in = CAL_IDLE;
                        settle_in    = 16'd0;
                     end
                     default: begin
                        cal_phase_in = CAL_IDLE;
                     end
                  endcase
               end
               rsp_valid_in = 1'b1;
               rsp_mech_in  = mech_ff;
               rsp_elec_in  = elec_ff;
               rsp_rpm_in   = rpm_ff;
               rsp_mneg_in  = votes_in[15];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         counts_per_rev_ff  <= 16'd4096;
         angle_gain_ff      <= 32'd1048576;
         pole_pair_count_ff <= 6'd1;
         speed_gain_ff      <= 32'd65536;
         settle_steps_ff    <= 16'd30000;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_COUNTS_PER_REV:  counts_per_rev_ff  <= csr_data[15:0];
            REG_ANGLE_GAIN:      angle_gain_ff      <= csr_data;
            REG_POLE_PAIR_COUNT: pole_pair_count_ff <= csr_data[5:0];
            REG_SPEED_GAIN:      speed_gain_ff      <= csr_data;
            REG_SETTLE_STEPS:    settle_steps_ff    <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control state and persistent block state
   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff      <= 5'd0;
         rsp_valid_ff  <= 1'b0;
         prev_count_ff <= 16'd0;
         votes_ff      <= 16'sd0;
         offset_ff     <= 16'd0;
         cal_phase_ff  <= CAL_IDLE;
         settle_ff     <= 16'd0;
      end else begin
         steps_ff      <= steps_in;
         rsp_valid_ff  <= rsp_valid_in;
         prev_count_ff <= prev_count_in;
         votes_ff      <= votes_in;
         offset_ff     <= offset_in;
         cal_phase_ff  <= cal_phase_in;
         settle_ff     <= settle_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      cnt_ff      <= cnt_in;
      down_ff     <= down_in;
      wraps_ff    <= wraps_in;
      index_ff    <= index_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      acc_ff      <= acc_in;
      mech_ff     <= mech_in;
      elec_ff     <= elec_in;
      rpm_ff      <= rpm_in;
      neg_ff      <= neg_in;
      rsp_mech_ff <= rsp_mech_in;
      rsp_elec_ff <= rsp_elec_in;
      rsp_rpm_ff  <= rsp_rpm_in;
      rsp_done_ff <= rsp_done_in;
      rsp_mneg_ff <= rsp_mneg_in;
   end

   // an accepted item always starts the angle multiply
   `ABZ_ASSERT_NXT(a_accept_starts, req_take, state_ff == ST_FRAC)
   // the speed multiply runs only for a speed command
   `ABZ_ASSERT_IMP(a_speed_cmd, state_ff == ST_SPEED, cmd_ff == CMD_SPEED)
   // the step count never exceeds the longest multiplier
   `ABZ_ASSERT_IMP(a_steps_bound, 1'b1, steps_ff <= SPEED_STEPS)
   // a stalled result holds back the commit of the next one
   `ABZ_ASSERT_NXT(a_finish_waits, (state_ff == ST_FINISH) && rsp_valid_ff && rsp_stall,
                   state_ff == ST_FINISH)

endmodule
